>>> sv/etf_pkg.sv
`timescale 1ns / 1ps

package etf_pkg;

    localparam int WIDTH_PIXELS  = 1024;
    localparam int HEIGHT_PIXELS = 1024;
    localparam int FRAC_BITS     = 28;
    localparam int ITER_BITS     = 10;
    localparam int COORD_BITS    = 10;
    localparam int CFG_IDX_W     = 3;

    // |z|^2 >= 4.0 in the double-width square domain
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RE_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IM_STEP    = 3'd7;

    localparam logic [1:0] MODE_MANDEL = 2'd0;
    localparam logic [1:0] MODE_JULIA  = 2'd1;
    localparam logic [1:0] MODE_SHIP   = 2'd2;

    localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(100);
    localparam logic signed [31:0]   ORIGIN_RST   = -32'sd536870912;
    localparam logic signed [31:0]   STEP_RST     = 32'sd1048576;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_etf_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [ITER_BITS-1:0]  iterations;
    } t_etf_out;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

>>> sv/escape_time_fractal_iterator_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        input      i_in_valid/o_in_stall   i_in_data  (pixel_x, pixel_y)
// out       output     o_out_valid/i_out_stall o_out_data (out_x, out_y, iterations)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one pixel at a time: take it, form the point, then iterate (square, escape test,
// update) until escape or max_iter and hand the result over; a pixel outside the frame
// goes straight to the handover; all steps share the single 32x32 multiplier
// o_in_stall is high from transaction accept until the result moves to the output register
// a finished result waits in the output register while the next pixel is taken
// reset (synchronous, active low) restores the register defaults and empties the block

module escape_time_fractal_iterator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  etf_pkg::t_etf_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output etf_pkg::t_etf_out                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [etf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PT_X  = 4'd1;
    localparam logic [3:0] S_PT_Y  = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_SQR_R = 4'd4;
    localparam logic [3:0] S_SQR_I = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int IB = etf_pkg::ITER_BITS;
    localparam int CB = etf_pkg::COORD_BITS;

    // configuration registers
    logic [1:0]         r_mode;
    logic [IB-1:0]      r_max_iter;
    logic signed [31:0] r_jc_re;
    logic signed [31:0] r_jc_im;
    logic signed [31:0] r_re_org;
    logic signed [31:0] r_im_org;
    logic signed [31:0] r_re_step;
    logic signed [31:0] r_im_step;

    logic [3:0]         r_state, n_state;
    logic [CB-1:0]      r_px, n_px;
    logic [CB-1:0]      r_py, n_py;
    logic signed [31:0] r_zr, n_zr;
    logic signed [31:0] r_zi, n_zi;
    logic signed [31:0] r_cr, n_cr;
    logic signed [31:0] r_ci, n_ci;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc, n_acc;
    logic [IB-1:0]      r_cnt, n_cnt;
    etf_pkg::t_etf_out  r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_pt_sum;
    logic signed [31:0] w_pt;
    logic [63:0]        w_mag;
    logic               w_escape;
    logic signed [63:0] w_re_new;
    logic signed [63:0] w_im_new;
    logic signed [63:0] w_re_fix;
    logic signed [63:0] w_im_fix;
    logic [IB-1:0]      w_cnt_inc;
    logic               w_in_frame;
    logic               w_in_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_take   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= etf_pkg::MODE_MANDEL;
            r_max_iter <= etf_pkg::MAX_ITER_RST;
            r_jc_re    <= '0;
            r_jc_im    <= '0;
            r_re_org   <= etf_pkg::ORIGIN_RST;
            r_im_org   <= etf_pkg::ORIGIN_RST;
            r_re_step  <= etf_pkg::STEP_RST;
            r_im_step  <= etf_pkg::STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                etf_pkg::REG_MODE:       r_mode     <= i_cfg_data[1:0];
                etf_pkg::REG_MAX_ITER:   r_max_iter <= i_cfg_data[IB-1:0];
                etf_pkg::REG_JULIA_C_RE: r_jc_re    <= i_cfg_data;
                etf_pkg::REG_JULIA_C_IM: r_jc_im    <= i_cfg_data;
                etf_pkg::REG_RE_ORIGIN:  r_re_org   <= i_cfg_data;
                etf_pkg::REG_IM_ORIGIN:  r_im_org   <= i_cfg_data;
                etf_pkg::REG_RE_STEP:    r_re_step  <= i_cfg_data;
                etf_pkg::REG_IM_STEP:    r_im_step  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_PT_X: begin
                w_mul_a = $signed(32'(r_px));
                w_mul_b = r_re_step;
            end
            S_PT_Y: begin
                w_mul_a = $signed(32'(r_py));
                w_mul_b = r_im_step;
            end
            S_SQR_R: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            S_SQR_I: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // point = origin + pixel * step, product sits in r_prod
    assign w_pt_sum = ((r_state == S_PT_Y) ? 64'(r_re_org) : 64'(r_im_org)) + r_prod;
    assign w_pt     = etf_pkg::sat32(w_pt_sum);

    // both squares are non-negative, the sum is at most 2^63 and fits unsigned 64 bits
    assign w_mag    = $unsigned(r_acc) + $unsigned(r_prod);
    assign w_escape = ((w_mag >> etf_pkg::ESC_SHIFT) != 64'd0);

    // r_acc holds zr^2 - zi^2, r_prod holds zr*zi in the update cycle
    assign w_re_new = (r_acc >>> etf_pkg::FRAC_BITS) + 64'(r_cr);
    assign w_im_new = (r_prod >>> (etf_pkg::FRAC_BITS - 1)) + 64'(r_ci);
    assign w_re_fix = ((r_mode == etf_pkg::MODE_SHIP) && (w_re_new < 0)) ? -w_re_new : w_re_new;
    assign w_im_fix = ((r_mode == etf_pkg::MODE_SHIP) && (w_im_new < 0)) ? -w_im_new : w_im_new;

    assign w_cnt_inc  = IB'(r_cnt + 1'b1);
    assign w_in_frame = (32'(i_in_data.pixel_x) < 32'(etf_pkg::WIDTH_PIXELS)) &&
                        (32'(i_in_data.pixel_y) < 32'(etf_pkg::HEIGHT_PIXELS));

    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_px  = i_in_data.pixel_x;
                    n_py  = i_in_data.pixel_y;
                    n_cnt = '0;
                    n_state = w_in_frame ? S_PT_X : S_DONE;
                end
            end
            S_PT_X: begin
                n_state = S_PT_Y;
            end
            S_PT_Y: begin
                n_cr    = w_pt;
                n_state = S_INIT;
            end
            S_INIT: begin
                if (r_mode == etf_pkg::MODE_JULIA) begin
                    n_zr = r_cr;
                    n_zi = w_pt;
                    n_cr = r_jc_re;
                    n_ci = r_jc_im;
                end else begin
                    n_zr = '0;
                    n_zi = '0;
                    n_ci = w_pt;
                end
                n_state = (r_max_iter == '0) ? S_DONE : S_SQR_R;
            end
            S_SQR_R: begin
                n_state = S_SQR_I;
            end
            S_SQR_I: begin
                n_acc   = r_prod;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                if (w_escape) begin
                    n_state = S_DONE;
                end else begin
                    n_acc   = r_acc - r_prod;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_zr    = etf_pkg::sat32(w_re_fix);
                n_zi    = etf_pkg::sat32(w_im_fix);
                n_cnt   = w_cnt_inc;
                n_state = (w_cnt_inc < r_max_iter) ? S_SQR_R : S_DONE;
            end
            S_DONE: begin
                // output register free or draining this cycle
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_x      = r_px;
                    n_out.out_y      = r_py;
                    n_out.iterations = r_cnt;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px   <= n_px;
        r_py   <= n_py;
        r_zr   <= n_zr;
        r_zi   <= n_zi;
        r_cr   <= n_cr;
        r_ci   <= n_ci;
        r_prod <= w_prod;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

endmodule

>>> sv/etf_checker.sv
`timescale 1ns / 1ps

module etf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input etf_pkg::t_etf_in              i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input etf_pkg::t_etf_out             o_out_data
);

    etf_pkg::t_etf_in r_last_in;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_last_in <= i_in_data;
        end
    end

    // one pixel at a time: the input side closes right after a transaction
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a pixel is in flight");

    // a fresh result carries the coordinates of the pixel that was taken
    a_coords_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_data.out_x == r_last_in.pixel_x) &&
                               (o_out_data.out_y == r_last_in.pixel_y))
        else $error("result coordinates do not match the last pixel");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind escape_time_fractal_iterator_core etf_checker u_etf_checker (.*);
